/* sv/wgm_pkg.sv */
// ============================================================================
// wgm_pkg: shared definitions for the wildcard glob matcher
// Command codes, wildcard characters, case folding and the control bundle
// that the core broadcasts to every pattern cell.
// ============================================================================
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int CHAR_W          = 8;
    localparam int CMD_W           = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic [CHAR_W-1:0] WILD_ONE = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] WILD_ANY = 8'h2A;  // '*'

    localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;

    // Broadcast to all cells for one accepted item.
    typedef struct packed {
        logic              load;
        logic              text;
        logic              clear;
        logic [CHAR_W-1:0] ch;
    } t_cell_ctrl;

    // Folds 'A'..'Z' onto 'a'..'z'; everything else passes unchanged.
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

endpackage

/* sv/wildcard_glob_match_core.sv */
// ============================================================================
// wildcard_glob_match_core: case-blind glob matcher with '?' and '*'
// Loads a pattern one character at a time into a row of cells, then runs
// text through it as an NFA and reports the match on a finish item.
// ============================================================================
// The block takes one item in every clock cycle: a pattern character, a text
// character or a finish command, carried in tuser. Every pattern position is
// a cell that stores its character and its active bit, and a text character
// updates all positions at once, so there is no per-character iteration. The
// only thing that can hold off the input is the single output register: a
// finish item needs a free result slot, and the input stalls only while a
// result sits there and the sink is not ready. A finish result is registered
// and shows on the output in the cycle after the finish item is taken. Up to
// PATTERN_MAX pattern characters are kept; further ones are dropped and
// reported as overflow with the result. The pattern store needs no clearing
// after reset, so the block is ready as soon as reset is released.
// ============================================================================
module wildcard_glob_match_core #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input item stream.
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [wgm_pkg::CHAR_W-1:0]   i_s_axis_tdata,   // [7:0] character
    input  logic [wgm_pkg::CMD_W-1:0]    i_s_axis_tuser,   // [1:0] cmd
    // Result stream.
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [7:0]                   o_m_axis_tdata,   // [0] matched, [7:1] zero
    output logic                         o_m_axis_tuser    // [0] overflow
);
    import wgm_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic                   w_in_acc;
    logic                   w_load;
    logic                   w_text;
    logic                   w_finish;
    t_cell_ctrl             w_ctrl;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_ovf;
    logic                   n_ovf;
    logic                   r_final;
    logic                   n_final;

    logic                   r_m_valid;
    logic                   r_matched;
    logic                   r_overflow;

    logic [PATTERN_MAX-1:0] w_cell_active;
    logic [PATTERN_MAX-1:0] w_star;
    logic [PATTERN_MAX-1:0] w_adv;
    logic [PATTERN_MAX-1:0] w_adv_in;
    logic [PATTERN_MAX:0]   w_active;
    logic [PATTERN_MAX:0]   w_closed;

    // The result register frees up when it is empty or drained this cycle.
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = w_in_acc && (i_s_axis_tuser == CMD_LOAD);
    assign w_text   = w_in_acc && (i_s_axis_tuser == CMD_TEXT);
    assign w_finish = w_in_acc && (i_s_axis_tuser == CMD_FINISH);

    assign w_ctrl.load  = w_load;
    assign w_ctrl.text  = w_text;
    assign w_ctrl.clear = w_finish;
    assign w_ctrl.ch    = i_s_axis_tdata;

    // Position 0 never receives an advance from the left.
    assign w_adv_in = {w_adv[PATTERN_MAX-2:0], 1'b0};
    // The position past the last cell is held here, not in a cell.
    assign w_active = {r_final, w_cell_active};

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        wgm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .INDEX       (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_count  (r_count),
            .i_closed (w_closed[g]),
            .i_adv    (w_adv_in[g]),
            .o_active (w_cell_active[g]),
            .o_star   (w_star[g]),
            .o_adv    (w_adv[g])
        );
    end

    wgm_closure #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_closure (
        .i_active (w_active),
        .i_star   (w_star),
        .o_closed (w_closed)
    );

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_final = r_final;
        if (w_finish) begin
            n_count = '0;
            n_ovf   = 1'b0;
            n_final = 1'b0;
        end else if (w_load) begin
            if (r_count < CNT_W'(PATTERN_MAX)) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end else if (w_text) begin
            n_final = w_adv[PATTERN_MAX-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_final   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_final <= n_final;
            if (w_finish) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // The whole text matched when the closure reaches the end of the pattern.
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_matched  <= w_closed[r_count];
            r_overflow <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'b0, r_matched};
    assign o_m_axis_tuser  = r_overflow;

endmodule

/* sv/wgm_cell.sv */
// ============================================================================
// wgm_cell: one pattern position
// Holds one pattern character and the active bit of its position, and hands
// an advance bit to the next cell when it consumes a text character.
// ============================================================================
module wgm_cell #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
    parameter int INDEX       = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wgm_pkg::t_cell_ctrl                    i_ctrl,
    input  logic [$clog2(PATTERN_MAX+1)-1:0]       i_count,
    input  logic                                   i_closed,
    input  logic                                   i_adv,
    output logic                                   o_active,
    output logic                                   o_star,
    output logic                                   o_adv
);
    import wgm_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic [CHAR_W-1:0] r_char;
    logic              r_active;
    logic              n_active;
    logic              w_used;
    logic              w_hit;

    // The cell holds a live pattern character only below the fill count.
    assign w_used = CNT_W'(INDEX) < i_count;
    assign o_star = w_used && (r_char == WILD_ANY);
    assign w_hit  = i_closed && w_used &&
                    ((r_char == WILD_ANY) || (r_char == WILD_ONE) ||
                     (fold(r_char) == fold(i_ctrl.ch)));

    assign o_adv    = w_hit;
    assign o_active = r_active;

    always_comb begin
        n_active = r_active;
        if (i_ctrl.clear) begin
            n_active = (INDEX == 0);
        end else if (i_ctrl.text) begin
            // A star keeps its position alive; the left neighbor may advance in.
            n_active = (i_closed && o_star) || i_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (INDEX == 0);
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && (i_count == CNT_W'(INDEX))) begin
            r_char <= i_ctrl.ch;
        end
    end

endmodule

/* sv/wgm_closure.sv */
// ============================================================================
// wgm_closure: star closure of the active set
// Spreads each active position across following stars. The spread is a
// carry chain (generate = active star, propagate = star), built as one add.
// ============================================================================
module wgm_closure #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX:0]   i_active,
    input  logic [PATTERN_MAX-1:0] i_star,
    output logic [PATTERN_MAX:0]   o_closed
);
    import wgm_pkg::*;

    logic [PATTERN_MAX:0] w_a;
    logic [PATTERN_MAX:0] w_b;
    logic [PATTERN_MAX:0] w_sum;
    logic [PATTERN_MAX:0] w_carry;

    assign w_a     = {1'b0, i_star};
    assign w_b     = {1'b0, i_star & i_active[PATTERN_MAX-1:0]};
    assign w_sum   = w_a + w_b;
    // Carry into bit k is set when position k-1 is a star inside the closure.
    assign w_carry = w_sum ^ w_a ^ w_b;
    assign o_closed = i_active | {w_carry[PATTERN_MAX:1], 1'b0};

endmodule

/* sv/wgm_checker.sv */
// ============================================================================
// wgm_checker: port-level checks for the glob matcher
// Watches the stream ports of the core and is bound to it below.
// ============================================================================
module wgm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic [wgm_pkg::CMD_W-1:0]  i_s_axis_tuser,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [7:0]                 o_m_axis_tdata,
    input logic                       o_m_axis_tuser
);
    import wgm_pkg::*;

    logic w_fin_acc;
    assign w_fin_acc = i_s_axis_tvalid && o_s_axis_tready &&
                       (i_s_axis_tuser == CMD_FINISH);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_acc |=> o_m_axis_tvalid)
        else $error("finish item gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !$past(o_m_axis_tvalid)) |-> $past(w_fin_acc))
        else $error("result without a finish item");

    a_empty_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_acc ##1 w_fin_acc) |=> (o_m_axis_tdata[0] && !o_m_axis_tuser))
        else $error("empty pattern and empty text did not match");

endmodule

bind wildcard_glob_match_core wgm_checker u_wgm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
